// ===== design/sqsw_pkg.sv =====
// ----------------------------------------------------------------------------
// sqsw_pkg
// Shared types, constants and helpers for the square channel with sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package sqsw_pkg;

    localparam int CMD_W    = 4;
    localparam int DATA_W   = 8;
    localparam int VOL_W    = 4;
    localparam int FREQ_W   = 11;
    localparam int PERIOD_W = 14;

    localparam logic [FREQ_W-1:0] MAX_FREQ = 11'd2047;

    localparam logic [7:0] SWEEP_CTRL_RST = 8'h80;
    localparam logic [7:0] DUTY_RD_FILL   = 8'h3f;
    localparam logic [1:0] DUTY_SEL_RST   = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SWEEP_WR = 4'd0,
        CMD_DUTY_WR  = 4'd1,
        CMD_FREQ_LO  = 4'd2,
        CMD_FREQ_HI  = 4'd3,
        CMD_TRIGGER  = 4'd4,
        CMD_TICK     = 4'd5,
        CMD_DUTY_STP = 4'd6,
        CMD_SWEEP_RD = 4'd7,
        CMD_DUTY_RD  = 4'd8
    } cmd_t;

    localparam logic [7:0] DUTY_WAVES [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    // Shadow shifted and added/subtracted; bit 11 set means above MAX_FREQ.
    function automatic logic [FREQ_W:0] sweep_calc(
        input logic [FREQ_W-1:0] shadow,
        input logic [2:0]        shift,
        input logic              sub
    );
        logic [FREQ_W:0] delta;
        delta = {1'b0, shadow >> shift};
        if (sub)
            sweep_calc = {1'b0, shadow} - delta;
        else
            sweep_calc = {1'b0, shadow} + delta;
    endfunction

    function automatic logic duty_bit(
        input logic [1:0] sel,
        input logic [2:0] pos
    );
        logic [7:0] wave;
        wave     = DUTY_WAVES[sel];
        duty_bit = wave[pos];
    endfunction

endpackage

`default_nettype wire

// ===== design/square_channel_frequency_sweep.sv =====
// ----------------------------------------------------------------------------
// square_channel_frequency_sweep
// Square-wave channel state with frequency sweep; one command per item.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   command   cmd_valid / cmd_ready  command, data, env_volume
//   result    res_valid / res_ready  enabled, volume, frequency, timer_period,
//                                    read_data
//
// One item per cycle while cmd_ready is high; its result follows next cycle.
// The sweep/overflow logic and the result register sit in a single stage.
// cmd_ready is high whenever the result register is empty or being drained.
// Reset (rst_n low, async): channel on, sweep ctrl 0x80, duty select 2.
// ----------------------------------------------------------------------------
`default_nettype none

module square_channel_frequency_sweep (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire logic [sqsw_pkg::CMD_W-1:0]      command,
    input  wire logic [sqsw_pkg::DATA_W-1:0]     data,
    input  wire logic [sqsw_pkg::VOL_W-1:0]      env_volume,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic                                 enabled,
    output logic [sqsw_pkg::VOL_W-1:0]           volume,
    output logic [sqsw_pkg::FREQ_W-1:0]          frequency,
    output logic [sqsw_pkg::PERIOD_W-1:0]        timer_period,
    output logic [sqsw_pkg::DATA_W-1:0]          read_data
);
    import sqsw_pkg::*;

    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [FREQ_W-1:0]   shadow_reg, shadow_next;
    logic [7:0]          sweep_ctrl_reg, sweep_ctrl_next;
    logic [3:0]          countdown_reg, countdown_next;
    logic                sweep_active_reg, sweep_active_next;
    logic                chan_on_reg, chan_on_next;
    logic [1:0]          duty_sel_reg, duty_sel_next;
    logic [2:0]          duty_pos_reg, duty_pos_next;

    logic                res_valid_reg;
    logic                enabled_reg;
    logic [VOL_W-1:0]    volume_reg;
    logic [FREQ_W-1:0]   frequency_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DATA_W-1:0]   rd_reg, rd_next;

    logic                accept;
    logic [2:0]          sw_period;
    logic [2:0]          sw_shift;
    logic                sw_sub;
    logic [3:0]          reload_val;
    logic [FREQ_W:0]     calc_first;
    logic [FREQ_W:0]     calc_second;
    logic [FREQ_W:0]     calc_trig;
    logic [FREQ_W:0]     period_base;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;

    assign sw_period  = sweep_ctrl_reg[6:4];
    assign sw_sub     = sweep_ctrl_reg[3];
    assign sw_shift   = sweep_ctrl_reg[2:0];
    assign reload_val = (sw_period == 3'd0) ? 4'd8 : {1'b0, sw_period};

    // First calc from shadow, second re-check on the written-back value
    assign calc_first  = sweep_calc(shadow_reg, sw_shift, sw_sub);
    assign calc_second = sweep_calc(calc_first[FREQ_W-1:0], sw_shift, sw_sub);
    assign calc_trig   = sweep_calc(freq_reg, sw_shift, sw_sub);

    always_comb
    begin
        freq_next         = freq_reg;
        shadow_next       = shadow_reg;
        sweep_ctrl_next   = sweep_ctrl_reg;
        countdown_next    = countdown_reg;
        sweep_active_next = sweep_active_reg;
        chan_on_next      = chan_on_reg;
        duty_sel_next     = duty_sel_reg;
        duty_pos_next     = duty_pos_reg;
        rd_next           = '0;

        unique case (cmd_t'(command))
            CMD_SWEEP_WR: sweep_ctrl_next = data;
            CMD_DUTY_WR:  duty_sel_next = data[7:6];
            CMD_FREQ_LO:  freq_next = {freq_reg[FREQ_W-1:8], data};
            CMD_FREQ_HI:  freq_next = {data[2:0], freq_reg[7:0]};
            CMD_TRIGGER:
            begin
                chan_on_next      = 1'b1;
                shadow_next       = freq_reg;
                countdown_next    = reload_val;
                sweep_active_next = (sw_period != 3'd0) || (sw_shift != 3'd0);
                if ((sw_shift != 3'd0) && calc_trig[FREQ_W])
                    chan_on_next = 1'b0;
            end
            CMD_TICK:
            begin
                if (countdown_reg <= 4'd1)
                begin
                    countdown_next = reload_val;
                    if ((sw_period != 3'd0) && sweep_active_reg)
                    begin
                        if (calc_first[FREQ_W])
                            chan_on_next = 1'b0;
                        else if (sw_shift != 3'd0)
                        begin
                            freq_next   = calc_first[FREQ_W-1:0];
                            shadow_next = calc_first[FREQ_W-1:0];
                            if (calc_second[FREQ_W])
                                chan_on_next = 1'b0;
                        end
                    end
                end
                else
                    countdown_next = countdown_reg - 4'd1;
            end
            CMD_DUTY_STP: duty_pos_next = duty_pos_reg + 3'd1;
            CMD_SWEEP_RD: rd_next = sweep_ctrl_reg;
            CMD_DUTY_RD:  rd_next = {duty_sel_reg, DUTY_RD_FILL[5:0]};
            default:      rd_next = '0;
        endcase
    end

    assign period_base = {1'b0, MAX_FREQ} + {{FREQ_W{1'b0}}, 1'b1} - {1'b0, freq_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg         <= '0;
            shadow_reg       <= '0;
            sweep_ctrl_reg   <= SWEEP_CTRL_RST;
            countdown_reg    <= '0;
            sweep_active_reg <= 1'b0;
            chan_on_reg      <= 1'b1;
            duty_sel_reg     <= DUTY_SEL_RST;
            duty_pos_reg     <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                freq_reg         <= freq_next;
                shadow_reg       <= shadow_next;
                sweep_ctrl_reg   <= sweep_ctrl_next;
                countdown_reg    <= countdown_next;
                sweep_active_reg <= sweep_active_next;
                chan_on_reg      <= chan_on_next;
                duty_sel_reg     <= duty_sel_next;
                duty_pos_reg     <= duty_pos_next;
                res_valid_reg    <= 1'b1;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            enabled_reg   <= chan_on_next;
            volume_reg    <= duty_bit(duty_sel_next, duty_pos_next) ? env_volume : '0;
            frequency_reg <= freq_next;
            period_reg    <= {period_base, 2'b00};
            rd_reg        <= rd_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign enabled      = enabled_reg;
    assign volume       = volume_reg;
    assign frequency    = frequency_reg;
    assign timer_period = period_reg;
    assign read_data    = rd_reg;

endmodule

`default_nettype wire

// ===== tb/sv/sqsw_result_checker.sv =====
// ----------------------------------------------------------------------------
// sqsw_result_checker
// Watches both channels of the square channel with sweep, keeps its own copy
// of the channel state, queues the result of every accepted item and compares
// each returned result with the oldest one, field by field.
// ----------------------------------------------------------------------------
module sqsw_result_checker
    import sqsw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire logic                cmd_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [DATA_W-1:0]   data,
    input  wire logic [VOL_W-1:0]    env_volume,
    input  wire logic                res_valid,
    input  wire logic                res_ready,
    input  wire logic                enabled,
    input  wire logic [VOL_W-1:0]    volume,
    input  wire logic [FREQ_W-1:0]   frequency,
    input  wire logic [PERIOD_W-1:0] timer_period,
    input  wire logic [DATA_W-1:0]   read_data,
    output int                       mismatch_count,
    output int                       outstanding,
    output int                       compared
);

    typedef struct packed {
        logic                en;
        logic [VOL_W-1:0]    vol;
        logic [FREQ_W-1:0]   freq;
        logic [PERIOD_W-1:0] period;
        logic [DATA_W-1:0]   rdata;
    } channel_result_t;

    channel_result_t pending_results[$];

    logic [FREQ_W-1:0] freq_q;
    logic [FREQ_W-1:0] shadow_q;
    logic [7:0]        sweep_ctrl_q;
    logic [3:0]        sweep_count_q;
    logic              sweep_on_q;
    logic              chan_on_q;
    logic [1:0]        duty_sel_q;
    logic [2:0]        duty_pos_q;

    // shadow shifted by ctrl[2:0], then added or (ctrl[3]) subtracted; bit 11 = overflow
    function automatic logic [FREQ_W:0] swept_target(input logic [FREQ_W-1:0] base,
                                                     input logic [7:0] ctrl);
        logic [FREQ_W:0] step;
        step = {1'b0, base >> ctrl[2:0]};
        return ctrl[3] ? ({1'b0, base} - step) : ({1'b0, base} + step);
    endfunction

    // 12.5, 25, 50 and 75 percent waveforms
    function automatic logic duty_level(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] wave;
        case (sel)
            2'd0:    wave = 8'h01;
            2'd1:    wave = 8'h81;
            2'd2:    wave = 8'h87;
            default: wave = 8'h7E;
        endcase
        return wave[pos];
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] wr,
                                 input logic [VOL_W-1:0] env, output channel_result_t res);
        logic [FREQ_W:0] target;
        logic [2:0]      per;
        res.rdata = '0;
        per       = sweep_ctrl_q[6:4];
        case (cmd)
            CMD_SWEEP_WR: sweep_ctrl_q = wr;
            CMD_DUTY_WR:  duty_sel_q = wr[7:6];
            CMD_FREQ_LO:  freq_q[7:0] = wr;
            CMD_FREQ_HI:  freq_q[10:8] = wr[2:0];
            CMD_TRIGGER: begin
                chan_on_q     = 1'b1;
                shadow_q      = freq_q;
                sweep_count_q = (per == 3'd0) ? 4'd8 : {1'b0, per};
                sweep_on_q    = (per != 3'd0) || (sweep_ctrl_q[2:0] != 3'd0);
                if (sweep_ctrl_q[2:0] != 3'd0 && swept_target(shadow_q, sweep_ctrl_q) > MAX_FREQ)
                    chan_on_q = 1'b0;
            end
            CMD_TICK: begin
                if (sweep_count_q <= 4'd1) begin
                    sweep_count_q = (per == 3'd0) ? 4'd8 : {1'b0, per};
                    if (per != 3'd0 && sweep_on_q) begin
                        target = swept_target(shadow_q, sweep_ctrl_q);
                        if (target > MAX_FREQ)
                            chan_on_q = 1'b0;
                        else if (sweep_ctrl_q[2:0] != 3'd0) begin
                            freq_q   = target[FREQ_W-1:0];
                            shadow_q = freq_q;
                            // second pass only checks for overflow
                            if (swept_target(shadow_q, sweep_ctrl_q) > MAX_FREQ)
                                chan_on_q = 1'b0;
                        end
                    end
                end else
                    sweep_count_q = sweep_count_q - 4'd1;
            end
            CMD_DUTY_STP: duty_pos_q = duty_pos_q + 3'd1;
            CMD_SWEEP_RD: res.rdata = sweep_ctrl_q;
            CMD_DUTY_RD:  res.rdata = {duty_sel_q, 6'h3f};
            default: ;
        endcase
        res.en     = chan_on_q;
        res.vol    = duty_level(duty_sel_q, duty_pos_q) ? env : '0;
        res.freq   = freq_q;
        res.period = PERIOD_W'((2048 - int'(freq_q)) * 4);
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        channel_result_t want;
        channel_result_t fresh;
        if (!rst_n) begin
            freq_q        = '0;
            shadow_q      = '0;
            sweep_ctrl_q  = SWEEP_CTRL_RST;
            sweep_count_q = '0;
            sweep_on_q    = 1'b0;
            chan_on_q     = 1'b1;
            duty_sel_q    = DUTY_SEL_RST;
            duty_pos_q    = '0;
            pending_results.delete();
            outstanding    = 0;
            mismatch_count = 0;
            compared       = 0;
        end else begin
            // a result never belongs to the item accepted at the same edge
            if (res_valid && res_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, frequency %0d", $time,
                             frequency);
                end else begin
                    want = pending_results.pop_front();
                    compared++;
                    check_field("enabled", 16'(want.en), 16'(enabled));
                    check_field("volume", 16'(want.vol), 16'(volume));
                    check_field("frequency", 16'(want.freq), 16'(frequency));
                    check_field("timer_period", 16'(want.period), 16'(timer_period));
                    check_field("read_data", 16'(want.rdata), 16'(read_data));
                end
            end
            if (cmd_valid && cmd_ready) begin
                apply_command(command, data, env_volume, fresh);
                pending_results.push_back(fresh);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_square_channel_frequency_sweep.sv =====
// ----------------------------------------------------------------------------
// tb_square_channel_frequency_sweep
// Drives register writes, triggers, sweep ticks, duty steps and reads into the
// square channel with random gaps on both sides; the checker predicts and
// compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_square_channel_frequency_sweep;
    import sqsw_pkg::*;

    localparam int RANDOM_ITEMS  = 1450;
    localparam int CMD_UNUSED_LO = int'(CMD_DUTY_RD) + 1;
    localparam int CMD_UNUSED_HI = (1 << CMD_W) - 1;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    logic [CMD_W-1:0]    command;
    logic [DATA_W-1:0]   data;
    logic [VOL_W-1:0]    env_volume;
    logic                res_valid;
    logic                res_ready;
    logic                enabled;
    logic [VOL_W-1:0]    volume;
    logic [FREQ_W-1:0]   frequency;
    logic [PERIOD_W-1:0] timer_period;
    logic [DATA_W-1:0]   read_data;

    int mismatch_count;
    int outstanding;
    int compared;

    int items_driven   = 0;
    int triggers_sent  = 0;
    int ticks_sent     = 0;
    int send_calm_left = 0;
    bit send_calm      = 1'b0;

    always #5 clk = ~clk;

    square_channel_frequency_sweep u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command      (command),
        .data         (data),
        .env_volume   (env_volume),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .enabled      (enabled),
        .volume       (volume),
        .frequency    (frequency),
        .timer_period (timer_period),
        .read_data    (read_data)
    );

    sqsw_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command        (command),
        .data           (data),
        .env_volume     (env_volume),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .enabled        (enabled),
        .volume         (volume),
        .frequency      (frequency),
        .timer_period   (timer_period),
        .read_data      (read_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .compared       (compared)
    );

    function automatic logic [DATA_W-1:0] any_byte();
        return DATA_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [VOL_W-1:0] any_vol();
        return VOL_W'($urandom_range(15, 0));
    endfunction

    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] wr,
                              input logic [VOL_W-1:0] env);
        int gap;
        if (send_calm_left == 0) begin
            send_calm      = 1'($urandom_range(1, 0));
            send_calm_left = $urandom_range(80, 20);
        end
        send_calm_left--;
        gap = send_calm ? 0 : $urandom_range(19, 0);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= cmd;
        data       <= wr;
        env_volume <= env;
        do @(posedge clk); while (!cmd_ready);
        items_driven++;
        if (cmd == CMD_TRIGGER)
            triggers_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    // stop offering and wait for every queued result to come back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // program sweep and frequency, trigger, then run the sweep for a while
    task automatic run_sweep_sequence();
        logic [7:0] ctrl;
        int         ticks;
        ctrl = any_byte();
        if ($urandom_range(3, 0) == 0)
            ctrl[6:4] = 3'd1;   // fast sweep, reaches overflow sooner
        offer_item(CMD_SWEEP_WR, ctrl, any_vol());
        if ($urandom_range(3, 0) == 0)
            offer_item(CMD_DUTY_WR, any_byte(), any_vol());
        offer_item(CMD_FREQ_LO, any_byte(), any_vol());
        offer_item(CMD_FREQ_HI, any_byte(), any_vol());
        offer_item(CMD_TRIGGER, any_byte(), any_vol());
        ticks = $urandom_range(24, 1);
        repeat (ticks) begin
            offer_item(CMD_TICK, any_byte(), any_vol());
            case ($urandom_range(5, 0))
                0, 1:    offer_item(CMD_DUTY_STP, any_byte(), any_vol());
                2:       offer_item(CMD_SWEEP_RD, any_byte(), any_vol());
                3:       offer_item(CMD_DUTY_RD, any_byte(), any_vol());
                default: ;
            endcase
        end
    endtask

    task automatic scatter_noise();
        repeat ($urandom_range(4, 1))
            offer_item(CMD_W'($urandom_range(CMD_UNUSED_HI, 0)), any_byte(), any_vol());
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        int calm_left;
        bit calm;
        res_ready = 1'b0;
        taken     = 0;
        calm_left = 0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (calm_left == 0) begin
                calm      = 1'($urandom_range(1, 0));
                calm_left = $urandom_range(80, 20);
            end
            calm_left--;
            stall = calm ? 0 : $urandom_range(19, 0);
            // long hold-offs so the block backs up and stalls its input
            if (taken == 250 || taken == 1000)
                stall = 300;
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        bit paused;
        paused     = 1'b0;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        command    = CMD_SWEEP_RD;
        data       = '0;
        env_volume = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then a tick with the countdown at zero and sweep period zero
        offer_item(CMD_SWEEP_RD, 8'hff, 4'hf);
        offer_item(CMD_DUTY_RD, 8'hff, 4'hf);
        offer_item(CMD_TICK, 8'h00, 4'hf);
        // duty writes keep only bits 7:6
        offer_item(CMD_DUTY_WR, 8'hc0, 4'hf);
        offer_item(CMD_DUTY_STP, 8'h00, 4'hf);
        offer_item(CMD_DUTY_STP, 8'h00, 4'h0);
        offer_item(CMD_DUTY_WR, 8'h3f, 4'hf);
        offer_item(CMD_DUTY_RD, 8'h00, 4'h5);
        // frequency extremes; high write uses only bits 2:0
        offer_item(CMD_FREQ_LO, 8'hff, 4'ha);
        offer_item(CMD_FREQ_HI, 8'hff, 4'ha);
        offer_item(CMD_FREQ_HI, 8'hf8, 4'ha);
        offer_item(CMD_FREQ_LO, 8'h00, 4'ha);
        // no sweep at all: period and shift zero
        offer_item(CMD_SWEEP_WR, 8'h00, 4'h3);
        offer_item(CMD_TRIGGER, 8'hff, 4'h3);
        offer_item(CMD_TICK, 8'hff, 4'h3);
        // additive sweep, shift 1: written back, then the recheck overflows
        offer_item(CMD_FREQ_HI, 8'h04, 4'h7);
        offer_item(CMD_SWEEP_WR, 8'h11, 4'h7);
        offer_item(CMD_TRIGGER, 8'h00, 4'h7);
        offer_item(CMD_TICK, 8'h00, 4'h7);
        // volume while disabled is not gated
        offer_item(CMD_DUTY_STP, 8'h00, 4'hc);
        // shift zero: doubles the shadow and disables, no write-back
        offer_item(CMD_SWEEP_WR, 8'h10, 4'h1);
        offer_item(CMD_TRIGGER, 8'h00, 4'h1);
        offer_item(CMD_TICK, 8'h00, 4'h1);
        // subtracting sweep with the longest period
        offer_item(CMD_SWEEP_WR, 8'h79, 4'h9);
        offer_item(CMD_TRIGGER, 8'h00, 4'h9);
        repeat (7) offer_item(CMD_TICK, 8'h00, 4'h9);
        offer_item(CMD_W'(CMD_UNUSED_HI), 8'hff, 4'hf);
        offer_item(CMD_W'(CMD_UNUSED_LO), 8'h55, 4'h8);
        offer_item(CMD_SWEEP_RD, 8'h00, 4'h0);
        drain_results();

        while (items_driven < RANDOM_ITEMS) begin
            if (!paused && items_driven >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(9, 0) < 8)
                run_sweep_sequence();
            else
                scatter_noise();
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("Drove %0d items (%0d triggers, %0d sweep ticks), compared %0d results.",
                 items_driven, triggers_sent, ticks_sent, compared);
        if (mismatch_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sqsw_pkg.sv
design/square_channel_frequency_sweep.sv
tb/sv/sqsw_result_checker.sv
tb/sv/tb_square_channel_frequency_sweep.sv
